// ===== sv/cle_pkg.sv =====
// Package with the shared types, codes and field widths of the circular list engine.
`default_nettype none

package cle_pkg;

  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned POS_OUT_W   = 4;
  localparam int unsigned CNT_OUT_W   = 5;
  localparam int unsigned RES_W       = 1 + POS_OUT_W + CNT_OUT_W + 1;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned PAD_W       = OUT_TDATA_W - RES_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_FRONT = 2'd0,
    REQ_INS_BACK  = 2'd1,
    REQ_REMOVE    = 2'd2,
    REQ_SEARCH    = 2'd3
  } req_e;

  typedef struct packed {
    logic                 overflow;
    logic [CNT_OUT_W-1:0] entry_count;
    logic [POS_OUT_W-1:0] match_position;
    logic                 found;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/circular_list_engine.sv =====
// An insert writes its entry at the input transfer and then presents its result; a search
// or a remove is bounded by the single read port of the entry memory, which is scanned
// and then, for a remove, shifted one entry per cycle.
// One request at a time: the next transfer is taken once the result has moved to the
// output register.
// Reset clears the list to empty; entry memory contents are not cleared and need not be.
`default_nettype none

module circular_list_engine #(
  parameter int unsigned CAPACITY   = cle_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = cle_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [cle_pkg::VALUE_W-1:0]       s_axis_tdata,  // [31:0] value
  input  wire logic [cle_pkg::REQ_W-1:0]         s_axis_tuser,  // [1:0] req_type
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] found, [4:1] match_position, [9:5] entry_count, [10] overflow, [15:11] zero
  output logic [cle_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

  import cle_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic                  res_valid;
  logic                  res_ready;
  result_t               res;

  cle_ctrl #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_req_i   (req_e'(s_axis_tuser)),
    .in_value_i (s_axis_tdata),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  cle_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(DATA_WIDTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  cle_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_ready_o(res_ready),
    .res_i      (res),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== sv/cle_ram.sv =====
// Single-port-write, single-port-read synchronous memory holding the list entries.
`default_nettype none

module cle_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/cle_ctrl.sv =====
// Request sequencer: ring pointers, scan and shift passes over the entry memory.
`default_nettype none

module cle_ctrl #(
  parameter int unsigned CAPACITY   = cle_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = cle_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire cle_pkg::req_e                 in_req_i,
  input  wire logic [cle_pkg::VALUE_W-1:0]   in_value_i,
  output logic                               ram_we_o,
  output logic [$clog2(CAPACITY)-1:0]        ram_waddr_o,
  output logic [DATA_WIDTH-1:0]              ram_wdata_o,
  output logic                               ram_re_o,
  output logic [$clog2(CAPACITY)-1:0]        ram_raddr_o,
  input  wire logic [DATA_WIDTH-1:0]         ram_rdata_i,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output cle_pkg::result_t                   res_o
);

  import cle_pkg::*;

  localparam int unsigned PW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = PW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_e;

  state_e                state_q, state_d;
  logic [PW-1:0]         front_q, front_d;
  logic [CW-1:0]         count_q, count_d;
  req_e                  req_q, req_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [CW-1:0]         rd_pos_q, rd_pos_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic [PW-1:0]         cmp_pos_q, cmp_pos_d;
  logic                  found_q, found_d;
  logic [PW-1:0]         pos_q, pos_d;
  logic                  ovf_q, ovf_d;
  logic                  hit;
  logic                  accept;

  // Ring slot of a list position counted from the front.
  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] front,
                                            input logic [CW-1:0] pos);
    logic [SW-1:0] sum;
    sum = SW'(front) + SW'(pos);
    if (sum >= SW'(CAPACITY)) begin
      sum = sum - SW'(CAPACITY);
    end
    return sum[PW-1:0];
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign hit        = cmp_vld_q && (ram_rdata_i == val_q);

  assign res_o.found          = found_q;
  assign res_o.match_position = POS_OUT_W'(pos_q);
  assign res_o.entry_count    = CNT_OUT_W'(count_q);
  assign res_o.overflow       = ovf_q;

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    req_d       = req_q;
    val_d       = val_q;
    rd_pos_d    = rd_pos_q;
    cmp_vld_d   = cmp_vld_q;
    cmp_pos_d   = cmp_pos_q;
    found_d     = found_q;
    pos_d       = pos_q;
    ovf_d       = ovf_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = val_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d     = in_req_i;
          val_d     = DATA_WIDTH'(in_value_i);
          found_d   = 1'b0;
          pos_d     = '0;
          ovf_d     = 1'b0;
          rd_pos_d  = '0;
          cmp_vld_d = 1'b0;
          unique case (in_req_i)
            REQ_INS_FRONT, REQ_INS_BACK: begin
              state_d = ST_DONE;
              if (count_q == CW'(CAPACITY)) begin
                ovf_d = 1'b1;
              end else begin
                ram_we_o    = 1'b1;
                ram_wdata_o = DATA_WIDTH'(in_value_i);
                count_d     = count_q + 1'b1;
                if (in_req_i == REQ_INS_FRONT) begin
                  front_d     = (front_q == '0) ? PW'(CAPACITY - 1) : front_q - 1'b1;
                  ram_waddr_o = front_d;
                end else begin
                  ram_waddr_o = slot_of(front_q, count_q);
                end
              end
            end
            REQ_REMOVE, REQ_SEARCH: begin
              state_d = ST_SCAN;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      // One read issued per cycle; the compare works on the word read the cycle before.
      ST_SCAN: begin
        priority if (hit) begin
          found_d   = 1'b1;
          pos_d     = cmp_pos_q;
          cmp_vld_d = 1'b0;
          if (req_q == REQ_REMOVE) begin
            rd_pos_d = CW'(cmp_pos_q) + 1'b1;
            state_d  = ST_SHIFT;
          end else begin
            state_d = ST_DONE;
          end
        end else if (rd_pos_q < count_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = slot_of(front_q, rd_pos_q);
          cmp_vld_d   = 1'b1;
          cmp_pos_d   = PW'(rd_pos_q);
          rd_pos_d    = rd_pos_q + 1'b1;
        end else if (cmp_vld_q) begin
          cmp_vld_d = 1'b0;
        end else begin
          state_d = ST_DONE;
        end
      end

      // Entry i+1 is read while entry i is written back one slot lower. A slot is
      // never read after it has been overwritten, so no forwarding is needed.
      ST_SHIFT: begin
        if (cmp_vld_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = slot_of(front_q, CW'(cmp_pos_q));
          ram_wdata_o = ram_rdata_i;
        end
        if (rd_pos_q < count_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = slot_of(front_q, rd_pos_q);
          cmp_vld_d   = 1'b1;
          cmp_pos_d   = PW'(rd_pos_q - 1'b1);
          rd_pos_d    = rd_pos_q + 1'b1;
        end else begin
          cmp_vld_d = 1'b0;
          if (!cmp_vld_q) begin
            count_d = count_q - 1'b1;
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (res_ready_i) begin
          res_valid_o = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      front_q   <= '0;
      count_q   <= '0;
      req_q     <= REQ_SEARCH;
      val_q     <= '0;
      rd_pos_q  <= '0;
      cmp_vld_q <= 1'b0;
      cmp_pos_q <= '0;
      found_q   <= 1'b0;
      pos_q     <= '0;
      ovf_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      count_q   <= count_d;
      req_q     <= req_d;
      val_q     <= val_d;
      rd_pos_q  <= rd_pos_d;
      cmp_vld_q <= cmp_vld_d;
      cmp_pos_q <= cmp_pos_d;
      found_q   <= found_d;
      pos_q     <= pos_d;
      ovf_q     <= ovf_d;
    end
  end

  a_no_same_slot_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o && ram_re_o |-> ram_waddr_o != ram_raddr_o)
    else $error("read and write of the same slot in one cycle");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |->
      (count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1))
    else $error("entry count moved by more than one");

  a_front_moves_on_front_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q != $past(front_q) |-> $past(accept && in_req_i == REQ_INS_FRONT))
    else $error("front index moved without a front insert");

endmodule

`default_nettype wire

// ===== sv/cle_obuf.sv =====
// Output register that holds one result until the downstream transfer completes.
`default_nettype none

module cle_obuf (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              res_valid_i,
  output logic                                   res_ready_o,
  input  wire cle_pkg::result_t                  res_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [cle_pkg::OUT_TDATA_W-1:0]        out_data_o
);

  import cle_pkg::*;

  logic                   valid_q;
  logic [OUT_TDATA_W-1:0] data_q;

  assign res_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_valid_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      data_q <= {{PAD_W{1'b0}}, res_i.overflow, res_i.entry_count,
                 res_i.match_position, res_i.found};
    end
  end

endmodule

`default_nettype wire

// ===== dv/cle_result_checker.sv =====
`timescale 1ns / 1ps
// Checker for the circular list engine: mirrors the list, predicts each result, compares outputs.
module cle_result_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  input  wire logic                            s_axis_tready,
  input  wire logic [cle_pkg::VALUE_W-1:0]     s_axis_tdata,   // [31:0] value
  input  wire logic [cle_pkg::REQ_W-1:0]       s_axis_tuser,   // [1:0] req_type
  input  wire logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [0] found, [4:1] match_position, [9:5] entry_count, [10] overflow, [15:11] zero
  input  wire logic [cle_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output int unsigned                          error_count_o,
  output int unsigned                          pending_o
);

  import cle_pkg::*;

  localparam int unsigned CAPACITY = CAPACITY_DEF;

  // Front of the list is index 0 of the queue.
  logic [VALUE_W-1:0] list_model_q [$];
  result_t            pending_results_q [$];

  // Applies one request to the mirrored list and returns the result it must produce.
  function automatic result_t apply_request(req_e kind, logic [VALUE_W-1:0] value);
    result_t res;
    int      hit;
    res = '0;
    hit = -1;
    case (kind)
      REQ_INS_FRONT, REQ_INS_BACK: begin
        if (list_model_q.size() >= CAPACITY) begin
          res.overflow = 1'b1;
        end else if (kind == REQ_INS_FRONT) begin
          list_model_q.push_front(value);
        end else begin
          list_model_q.push_back(value);
        end
      end
      default: begin
        foreach (list_model_q[i]) begin
          if (hit < 0 && list_model_q[i] == value) hit = i;
        end
        if (hit >= 0) begin
          res.found          = 1'b1;
          res.match_position = hit[POS_OUT_W-1:0];
          if (kind == REQ_REMOVE) list_model_q.delete(hit);
        end
      end
    endcase
    res.entry_count = CNT_OUT_W'(list_model_q.size());
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t seen;
    result_t want;
    if (!rst_ni) begin
      list_model_q.delete();
      pending_results_q.delete();
      error_count_o = 0;
    end else begin
      // The result of a request never leaves in the cycle of its own transfer,
      // so the output side is checked before the new request is predicted.
      if (m_axis_tvalid && m_axis_tready) begin
        seen = result_t'(m_axis_tdata[RES_W-1:0]);
        if (pending_results_q.size() == 0) begin
          $error("result 0x%04h arrived with no request outstanding", m_axis_tdata);
          error_count_o++;
        end else begin
          want = pending_results_q.pop_front();
          check_field("found", want.found, seen.found);
          check_field("match_position", want.match_position, seen.match_position);
          check_field("entry_count", want.entry_count, seen.entry_count);
          check_field("overflow", want.overflow, seen.overflow);
          check_field("padding", '0, m_axis_tdata[OUT_TDATA_W-1:RES_W]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results_q.push_back(apply_request(req_e'(s_axis_tuser), s_axis_tdata));
      end
    end
    pending_o = pending_results_q.size();
  end

endmodule

// ===== dv/circular_list_engine_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the circular list engine: stimulus, flow control, watchdog and verdict.
module circular_list_engine_tb;
  import cle_pkg::*;

  localparam int unsigned CLK_HALF       = 4;
  localparam int unsigned HOLD_CYCLES    = 250;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned RANDOM_ITEMS   = 1000;
  localparam int unsigned SEGMENT_ITEMS  = 100;
  localparam int unsigned QUIET_ITEMS    = 150;
  localparam int unsigned HOLD_AT_ITEM   = 300;
  localparam int unsigned DRAIN_AT_ITEM  = 600;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  wire                    s_axis_tready;
  logic [VALUE_W-1:0]     s_axis_tdata;   // [31:0] value
  logic [REQ_W-1:0]       s_axis_tuser;   // [1:0] req_type
  wire                    m_axis_tvalid;
  logic                   m_axis_tready;
  // [0] found, [4:1] match_position, [9:5] entry_count, [10] overflow, [15:11] zero
  wire [OUT_TDATA_W-1:0]  m_axis_tdata;

  int unsigned error_count;
  int unsigned pending_count;
  bit          sink_hold;
  bit          quiet;

  circular_list_engine u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  cle_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .error_count_o (error_count),
    .pending_o     (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Offers one request and returns at the edge where its transfer happens.
  task automatic issue_request(req_e kind, logic [VALUE_W-1:0] value);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = value;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic sender_gap(int unsigned cycles);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Receiver flow control: random ready runs and stall bursts, one long hold on request.
  initial begin
    int unsigned run;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (sink_hold) begin
        m_axis_tready = 1'b0;
        run           = HOLD_CYCLES;
        sink_hold     = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        run           = $urandom_range(1, 18);
      end else begin
        m_axis_tready = 1'b1;
        run           = quiet ? 1 : $urandom_range(1, 40);
      end
      repeat (run) @(negedge clk_i);
    end
  end

  // Ends the run if no transfer happens on either side for too long.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("circular_list_engine_tb: done, errors");
    $finish;
  end

  initial begin
    logic [VALUE_W-1:0] value_pool [8];
    logic [VALUE_W-1:0] value;
    int unsigned        insert_pct;
    bit                 gaps_on;
    req_e               kind;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    sink_hold     = 1'b0;
    quiet         = 1'b0;
    insert_pct    = 50;
    gaps_on       = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: requests on an empty list, extreme values, duplicates, misses.
    issue_request(REQ_SEARCH, 32'h0000_0005);
    issue_request(REQ_REMOVE, 32'h0000_0005);
    issue_request(REQ_INS_FRONT, 32'h7FFF_FFFF);
    issue_request(REQ_INS_FRONT, 32'h8000_0000);
    issue_request(REQ_INS_BACK, 32'h0000_0000);
    issue_request(REQ_INS_BACK, 32'hFFFF_FFFF);
    issue_request(REQ_SEARCH, 32'h8000_0000);
    issue_request(REQ_SEARCH, 32'hFFFF_FFFF);
    issue_request(REQ_INS_BACK, 32'h7FFF_FFFF);
    // Only the first of the two equal entries goes away.
    issue_request(REQ_REMOVE, 32'h7FFF_FFFF);
    issue_request(REQ_REMOVE, 32'h1234_5678);
    issue_request(REQ_REMOVE, 32'h8000_0000);
    // Three entries are left; fill up to capacity, the last one at the back.
    for (int i = 1; i <= 13; i++) begin
      issue_request((i % 2) ? REQ_INS_BACK : REQ_INS_FRONT, 32'hA5A5_0000 | i);
    end
    issue_request(REQ_INS_FRONT, 32'h5A5A_5A5A);
    issue_request(REQ_INS_BACK, 32'h5A5A_5A5A);
    issue_request(REQ_SEARCH, 32'hA5A5_000D);
    issue_request(REQ_REMOVE, 32'hA5A5_000D);

    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7FFF_FFFF;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT_ITEMS == 0) begin
        // Each segment leans toward filling, draining or mixing the list.
        case ($urandom_range(0, 2))
          0:       insert_pct = 25;
          1:       insert_pct = 50;
          default: insert_pct = 85;
        endcase
        gaps_on = ($urandom_range(0, 3) != 0);
        for (int k = 4; k < 8; k++) value_pool[k] = $urandom;
      end
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if (n == HOLD_AT_ITEM) sink_hold = 1'b1;
      if (n == DRAIN_AT_ITEM) begin
        sender_gap(1);
        while (pending_count != 0) @(negedge clk_i);
      end

      if ($urandom_range(0, 99) < insert_pct) begin
        kind = $urandom_range(0, 1) ? REQ_INS_BACK : REQ_INS_FRONT;
      end else begin
        kind = $urandom_range(0, 1) ? REQ_SEARCH : REQ_REMOVE;
      end
      if ($urandom_range(0, 9) < 7) begin
        value = value_pool[$urandom_range(0, 7)];
      end else begin
        value = $urandom;
      end
      issue_request(kind, value);

      if (!quiet && gaps_on && $urandom_range(0, 4) == 0) begin
        sender_gap($urandom_range(1, 18));
      end
    end
    sender_gap(1);

    while (pending_count != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("circular_list_engine_tb: done, clean");
    end else begin
      $display("circular_list_engine_tb: done, errors");
    end
    $finish;
  end

endmodule
